// ===== design/pspp_pkg.sv =====
// ----------------------------------------------------------------------------
// pspp_pkg
// Shared types, constants and helpers for the phase scheduled pitch PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package pspp_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // angles in Q4.28 radians
   localparam logic signed [31:0] DEG_HALF = 32'sd2342541;
   localparam logic signed [31:0] DEG_2    = 32'sd9370165;
   localparam logic signed [31:0] DEG_6    = 32'sd28110495;
   localparam logic signed [31:0] DEG_10   = 32'sd46850825;
   localparam logic signed [31:0] DEG_15   = 32'sd70276238;
   localparam logic signed [31:0] DEG_20   = 32'sd93701651;
   localparam logic signed [31:0] DEG_30   = 32'sd140552476;

   // phase thresholds in Q20.12 seconds
   localparam logic [31:0] T_CLIMB    = 32'd8192;
   localparam logic [31:0] T_CRUISE   = 32'd2867200;
   localparam logic [31:0] T_DESCENT  = 32'd2990080;
   localparam logic [31:0] T_TERMINAL = 32'd3489792;

   // ceil(2^35 / 10), exact for 32 bit dividends
   localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

   localparam logic [2:0] PH_TAKEOFF  = 3'd0;
   localparam logic [2:0] PH_CLIMB    = 3'd1;
   localparam logic [2:0] PH_CRUISE   = 3'd2;
   localparam logic [2:0] PH_DESCENT  = 3'd3;
   localparam logic [2:0] PH_TERMINAL = 3'd4;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_CONTROL = 1'b1;

   typedef enum logic [1:0] {
      CSR_KP    = 2'd0,
      CSR_KI    = 2'd1,
      CSR_KD    = 2'd2,
      CSR_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_LATCH,
      OP_EMPTY,
      OP_RD_FIRST,
      OP_RD_LAST,
      OP_CHECK,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_MUL,
      OP_DIV_STEP,
      OP_INTERP,
      OP_OVR,
      OP_ERR,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_SUM
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MUL,
      ST_DIV,
      ST_INTERP,
      ST_OVR,
      ST_ERR,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_OUT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;     // table empty
      logic clamp;      // time outside the table span
      logic scan_more;  // segment search continues
      logic div_last;   // final divider step
   } dp_status_type;

   function automatic logic signed [31:0] phase_target(input logic [2:0] ph);
      logic signed [31:0] r;
      unique case (ph)
         PH_TAKEOFF: r = DEG_30;
         PH_CLIMB:   r = DEG_6;
         PH_DESCENT: r = -DEG_2;
         default:    r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/pspp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pspp_ctrl
// Sequencer: steps the datapath through search, divide and PID phases.
// ----------------------------------------------------------------------------
`default_nettype none

module pspp_ctrl
   import pspp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_CONTROL) state_in = ST_START;
         end
         ST_START:    state_in = status.n_zero ? ST_OVR : ST_RD_FIRST;
         ST_RD_FIRST: state_in = ST_RD_LAST;
         ST_RD_LAST:  state_in = ST_CHECK;
         ST_CHECK:    state_in = status.clamp ? ST_OVR : ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = status.scan_more ? ST_SCAN_RD : ST_MUL;
         ST_MUL:      state_in = ST_DIV;
         ST_DIV:      state_in = status.div_last ? ST_INTERP : ST_DIV;
         ST_INTERP:   state_in = ST_OVR;
         ST_OVR:      state_in = ST_ERR;
         ST_ERR:      state_in = ST_MUL1;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_MUL3;
         ST_MUL3:     state_in = ST_SUM;
         ST_SUM:      state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = (req_kind == KIND_CONTROL) ? OP_LATCH : OP_LOAD;
         end
         ST_START:    cmd.op = OP_EMPTY;
         ST_RD_FIRST: cmd.op = OP_RD_FIRST;
         ST_RD_LAST:  cmd.op = OP_RD_LAST;
         ST_CHECK:    cmd.op = OP_CHECK;
         ST_SCAN_RD:  cmd.op = OP_SCAN_RD;
         ST_SCAN_CHK: cmd.op = OP_SCAN_CHK;
         ST_MUL:      cmd.op = OP_MUL;
         ST_DIV:      cmd.op = OP_DIV_STEP;
         ST_INTERP:   cmd.op = OP_INTERP;
         ST_OVR:      cmd.op = OP_OVR;
         ST_ERR:      cmd.op = OP_ERR;
         ST_MUL1:     cmd.op = OP_MUL1;
         ST_MUL2:     cmd.op = OP_MUL2;
         ST_MUL3:     cmd.op = OP_MUL3;
         ST_SUM:      cmd.op = OP_SUM;
         ST_OUT:      rsp_valid = 1'b1;
         default:     cmd.op = OP_NONE;
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_ctrl_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_CONTROL) |=> state_ff == ST_START)
      else $error("control transfer did not start a step");

   a_load_stays: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_LOAD) |=> state_ff == ST_IDLE)
      else $error("load transfer left idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before transfer");

endmodule

`default_nettype wire

// ===== design/pspp_datapath.sv =====
// ----------------------------------------------------------------------------
// pspp_datapath
// Schedule table, segment search, serial divider and PID arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module pspp_datapath
   import pspp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire logic [6:0]         req_point_index,
   input  wire logic [31:0]        req_point_time,
   input  wire logic signed [31:0] req_point_angle,
   input  wire logic [31:0]        req_sample_time,
   input  wire logic signed [31:0] req_path_angle,
   input  wire logic signed [31:0] req_pitch_attitude,
   input  wire logic               csr_valid,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data,
   output logic signed [27:0]      rsp_attack_command,
   output logic signed [31:0]      rsp_target_angle,
   output logic [2:0]              rsp_flight_phase
);

   logic [31:0]        mem_time  [TABLE_DEPTH];
   logic signed [31:0] mem_angle [TABLE_DEPTH];

   logic signed [15:0] kp_ff, ki_ff, kd_ff;
   logic [7:0]         count_ff;

   logic [31:0]        t_ff;
   logic signed [31:0] path_ff, pitch_ff;
   logic [CNT_W-1:0]   n_ff, k_ff;
   logic [2:0]         phase_ff;

   logic [31:0]        rtime_ff, prev_time_ff;
   logic signed [31:0] rangle_ff, prev_angle_ff;
   logic [31:0]        num_ff, den_ff, mag_ff;
   logic               neg_ff;
   logic [64:0]        divq_ff;
   logic [31:0]        rem_ff;
   logic [6:0]         cnt_ff;

   logic signed [31:0] target_ff, err_ff, comp_ff, integ_ff, perr_ff;
   logic signed [47:0] p_ff, i_ff;
   logic signed [53:0] d_ff;
   logic signed [37:0] dx10_ff;
   logic [63:0]        r10_ff;
   logic signed [27:0] cmd_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= 16'sd8192;
         ki_ff    <= 16'sd410;
         kd_ff    <= 16'sd2048;
         count_ff <= 8'd0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP:    kp_ff    <= csr_data;
            CSR_KI:    ki_ff    <= csr_data;
            CSR_KD:    kd_ff    <= csr_data;
            CSR_COUNT: count_ff <= csr_data[7:0];
            default:   ;
         endcase
      end
   end

   // ---------------- table ----------------
   logic [31:0]       idx32;
   logic [CNT_W-1:0]  nm1;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   assign idx32 = 32'(req_point_index);
   assign nm1   = n_ff - CNT_W'(1);

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      unique case (cmd.op)
         OP_RD_FIRST: rd_addr = '0;
         OP_RD_LAST:  rd_addr = nm1[ADDR_W-1:0];
         OP_SCAN_RD:  rd_addr = k_ff[ADDR_W-1:0];
         default:     rd_en   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && idx32 < 32'(TABLE_DEPTH)) begin
         mem_time[idx32[ADDR_W-1:0]]  <= req_point_time;
         mem_angle[idx32[ADDR_W-1:0]] <= req_point_angle;
      end
      if (rd_en) begin
         rtime_ff  <= mem_time[rd_addr];
         rangle_ff <= mem_angle[rd_addr];
      end
   end

   // ---------------- combinational helpers ----------------
   logic [31:0]        cnt32;
   logic [CNT_W-1:0]   n_eff;
   logic [2:0]         phase_in;
   logic [32:0]        div_sh, div_tr;
   logic               div_ge;
   logic signed [33:0] interp_v;
   logic signed [31:0] pt;
   logic signed [32:0] ovr_d, ovr_abs, err_d, comp_d, aerr;
   logic signed [33:0] derr, int_sum;
   logic signed [31:0] e10, q10;
   logic               in_band;
   logic signed [43:0] sum_v;

   assign cnt32 = 32'(count_ff);
   assign n_eff = (cnt32 > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt32);

   always_comb begin
      priority if (req_sample_time < T_CLIMB)    phase_in = PH_TAKEOFF;
      else if (req_sample_time < T_CRUISE)       phase_in = PH_CLIMB;
      else if (req_sample_time < T_DESCENT)      phase_in = PH_CRUISE;
      else if (req_sample_time < T_TERMINAL)     phase_in = PH_DESCENT;
      else                                       phase_in = PH_TERMINAL;
   end

   assign div_sh = {rem_ff, divq_ff[64]};
   assign div_tr = div_sh - {1'b0, den_ff};
   assign div_ge = div_sh >= {1'b0, den_ff};

   assign interp_v = neg_ff ? 34'(prev_angle_ff) - $signed({1'b0, divq_ff[32:0]})
                            : 34'(prev_angle_ff) + $signed({1'b0, divq_ff[32:0]});

   assign pt      = phase_target(phase_ff);
   assign ovr_d   = 33'(target_ff) - 33'(pt);
   assign ovr_abs = ovr_d < 0 ? -ovr_d : ovr_d;
   assign err_d   = 33'(target_ff) - 33'(path_ff);
   assign comp_d  = (33'(pitch_ff) - 33'(path_ff)) >>> 1;
   assign aerr    = err_ff < 0 ? -33'(err_ff) : 33'(err_ff);
   assign derr    = 34'(err_ff) - 34'(perr_ff);

   assign in_band = aerr < 33'(DEG_15);
   assign q10     = $signed({3'b000, r10_ff[63:35]});
   assign e10     = err_ff < 0 ? -q10 : q10;
   assign int_sum = 34'(integ_ff) + (in_band ? 34'(e10) : 34'sd0);

   assign sum_v = 44'(p_ff >>> 12) + 44'(i_ff >>> 12) + 44'(d_ff >>> 12) + 44'(comp_ff);

   assign status.n_zero    = (n_ff == '0);
   assign status.clamp     = (t_ff <= prev_time_ff) || (t_ff >= rtime_ff);
   assign status.scan_more = (k_ff < nm1) && (t_ff > rtime_ff);
   assign status.div_last  = (cnt_ff == 7'd64);

   // ---------------- PID state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         perr_ff  <= '0;
         phase_ff <= PH_TAKEOFF;
      end else begin
         if (cmd.op == OP_LATCH) phase_ff <= phase_in;
         if (cmd.op == OP_MUL2) begin
            perr_ff <= err_ff;
            priority if (int_sum > 34'(DEG_10))       integ_ff <= DEG_10;
            else if (int_sum < -34'(DEG_10))          integ_ff <= -DEG_10;
            else                                      integ_ff <= int_sum[31:0];
         end
      end
   end

   // ---------------- working registers ----------------
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH: begin
            t_ff     <= req_sample_time;
            path_ff  <= req_path_angle;
            pitch_ff <= req_pitch_attitude;
            n_ff     <= n_eff;
         end
         OP_EMPTY: target_ff <= DEG_30;
         OP_RD_LAST: begin
            prev_time_ff  <= rtime_ff;
            prev_angle_ff <= rangle_ff;
            k_ff          <= CNT_W'(1);
         end
         OP_CHECK: begin
            if (t_ff <= prev_time_ff) target_ff <= prev_angle_ff;
            else if (t_ff >= rtime_ff) target_ff <= rangle_ff;
         end
         OP_SCAN_CHK: begin
            if (status.scan_more) begin
               prev_time_ff  <= rtime_ff;
               prev_angle_ff <= rangle_ff;
               k_ff          <= k_ff + CNT_W'(1);
            end else begin
               num_ff <= t_ff - prev_time_ff;
               den_ff <= rtime_ff - prev_time_ff;
               neg_ff <= rangle_ff < prev_angle_ff;
               mag_ff <= (rangle_ff < prev_angle_ff)
                         ? 32'(33'(prev_angle_ff) - 33'(rangle_ff))
                         : 32'(33'(rangle_ff) - 33'(prev_angle_ff));
            end
         end
         OP_MUL: begin
            divq_ff <= 65'(64'(mag_ff) * 64'(num_ff)) + 65'(den_ff >> 1);
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff  <= div_ge ? div_tr[31:0] : div_sh[31:0];
            divq_ff <= {divq_ff[63:0], div_ge};
            cnt_ff  <= cnt_ff + 7'd1;
         end
         OP_INTERP: target_ff <= interp_v[31:0];
         OP_OVR: begin
            if (ovr_abs > 33'(DEG_HALF)) target_ff <= pt;
         end
         OP_ERR: begin
            priority if (err_d > 33'sh0_7FFF_FFFF)     err_ff <= 32'sh7FFF_FFFF;
            else if (err_d < -33'sh0_8000_0000)        err_ff <= 32'sh8000_0000;
            else                                       err_ff <= err_d[31:0];
            comp_ff <= comp_d[31:0];
         end
         OP_MUL1: begin
            p_ff    <= 48'(kp_ff) * 48'(err_ff);
            r10_ff  <= 64'(aerr[31:0]) * 64'(RECIP_10);
            dx10_ff <= (38'(derr) <<< 3) + (38'(derr) <<< 1);
         end
         OP_MUL2: d_ff <= 54'(kd_ff) * 54'(dx10_ff);
         OP_MUL3: i_ff <= 48'(ki_ff) * 48'(integ_ff);
         OP_SUM: begin
            priority if (sum_v > 44'(DEG_20))   cmd_ff <= DEG_20[27:0];
            else if (sum_v < -44'(DEG_20))      cmd_ff <= 28'(-DEG_20);
            else                                cmd_ff <= sum_v[27:0];
         end
         default: ;
      endcase
   end

   assign rsp_attack_command = cmd_ff;
   assign rsp_target_angle   = target_ff;
   assign rsp_flight_phase   = phase_ff;

endmodule

`default_nettype wire

// ===== design/phase_scheduled_pitch_pid_core.sv =====
// ----------------------------------------------------------------------------
// phase_scheduled_pitch_pid_core
// Phase scheduled pitch PID with anti-windup and interpolated target table.
//
//   channel  ports   direction  transfer moves
//   req      req_*   in         table point load or control step
//   rsp      rsp_*   out        attack command, target, flight phase
//   csr      csr_*   in         gain and point count register write
//
// A load writes the table without leaving idle. A control step runs a
// sequential segment search of s (1 to 127) probes and the 65-step
// restoring divider of the interpolation before rsp_valid rises; clamped
// and empty-table steps skip both. Reset is synchronous; it clears control
// state, the point count and PID history and restores the default gains.
// A pending result holds the block; the next input is taken in the cycle
// after the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_scheduled_pitch_pid_core
   import pspp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [6:0]         req_point_index,
   input  wire logic [31:0]        req_point_time,
   input  wire logic signed [31:0] req_point_angle,
   input  wire logic [31:0]        req_sample_time,
   input  wire logic signed [31:0] req_path_angle,
   input  wire logic signed [31:0] req_pitch_attitude,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [27:0]      rsp_attack_command,
   output logic signed [31:0]      rsp_target_angle,
   output logic [2:0]              rsp_flight_phase,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   pspp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pspp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_point_index    (req_point_index),
      .req_point_time     (req_point_time),
      .req_point_angle    (req_point_angle),
      .req_sample_time    (req_sample_time),
      .req_path_angle     (req_path_angle),
      .req_pitch_attitude (req_pitch_attitude),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_attack_command (rsp_attack_command),
      .rsp_target_angle   (rsp_target_angle),
      .rsp_flight_phase   (rsp_flight_phase)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for phase_scheduled_pitch_pid_core. Loads schedule
// tables, sweeps gains and point counts, and runs control steps under random
// backpressure. A scoreboard predicts the attack command, target and phase.
// ----------------------------------------------------------------------------

module tb
   import pspp_pkg::*;
;

   typedef struct {
      logic               kind;
      logic [6:0]         index;
      logic [31:0]        ptime;
      logic signed [31:0] pangle;
      logic [31:0]        stime;
      logic signed [31:0] path;
      logic signed [31:0] pitch;
   } step_item_type;

   typedef struct {
      logic signed [27:0] command;
      logic signed [31:0] target;
      logic [2:0]         phase;
   } steer_result_type;

   class pitch_scoreboard_type;
      logic [31:0]        sched_time [TABLE_DEPTH];
      logic signed [31:0] sched_angle [TABLE_DEPTH];
      longint             integral, prev_err;
      int                 kp, ki, kd;
      int unsigned        count;
      steer_result_type   pending_q[$];
      int                 errors, checked, controls, loads;

      function new();
         kp = 8192;
         ki = 410;
         kd = 2048;
         count = 0;
         integral = 0;
         prev_err = 0;
      endfunction

      static function logic [2:0] phase_of(logic [31:0] t);
         if (t < T_CLIMB) return PH_TAKEOFF;
         if (t < T_CRUISE) return PH_CLIMB;
         if (t < T_DESCENT) return PH_CRUISE;
         if (t < T_TERMINAL) return PH_DESCENT;
         return PH_TERMINAL;
      endfunction

      static function longint fixed_target(logic [2:0] ph);
         case (ph)
            PH_TAKEOFF: return longint'(DEG_30);
            PH_CLIMB:   return longint'(DEG_6);
            PH_DESCENT: return -longint'(DEG_2);
            default:    return 0;
         endcase
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_KP:    kp = int'($signed(v));
            CSR_KI:    ki = int'($signed(v));
            CSR_KD:    kd = int'($signed(v));
            CSR_COUNT: count = v[7:0];
         endcase
      endfunction

      function longint interpolate(logic [31:0] t);
         int          n, k;
         longint      a0, diff;
         logic [63:0] num, den, mag, q;
         n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         k = 0;
         if (n == 0) return longint'(DEG_30);
         if (t <= sched_time[0]) return longint'(sched_angle[0]);
         if (t >= sched_time[n-1]) return longint'(sched_angle[n-1]);
         while (k + 1 < n - 1 && t > sched_time[k+1]) k++;
         num = {32'b0, t} - {32'b0, sched_time[k]};
         den = {32'b0, sched_time[k+1]} - {32'b0, sched_time[k]};
         a0 = sched_angle[k];
         diff = longint'(sched_angle[k+1]) - a0;
         mag = (diff < 0) ? -diff : diff;
         q = (mag * num + den / 2) / den;
         return (diff < 0) ? a0 - longint'(q) : a0 + longint'(q);
      endfunction

      function void note_input(step_item_type it);
         logic [2:0]       ph;
         longint           target, ft, err, p, i, d, comp, cmd;
         steer_result_type r;
         if (it.kind == KIND_LOAD) begin
            sched_time[it.index] = it.ptime;
            sched_angle[it.index] = it.pangle;
            loads++;
            return;
         end
         controls++;
         ph = phase_of(it.stime);
         target = interpolate(it.stime);
         ft = fixed_target(ph);
         if ((target - ft > longint'(DEG_HALF)) || (ft - target > longint'(DEG_HALF)))
            target = ft;
         err = target - longint'(it.path);
         if (err > 64'sd2147483647) err = 64'sd2147483647;
         if (err < -64'sd2147483648) err = -64'sd2147483648;
         p = (longint'(kp) * err) >>> 12;
         if (err < longint'(DEG_15) && -err < longint'(DEG_15))
            integral = integral + err / 10;
         if (integral > longint'(DEG_10)) integral = DEG_10;
         if (integral < -longint'(DEG_10)) integral = -longint'(DEG_10);
         i = (longint'(ki) * integral) >>> 12;
         d = (longint'(kd) * ((err - prev_err) * 10)) >>> 12;
         prev_err = err;
         comp = (longint'(it.pitch) - longint'(it.path)) >>> 1;
         cmd = p + i + d + comp;
         if (cmd > longint'(DEG_20)) cmd = DEG_20;
         if (cmd < -longint'(DEG_20)) cmd = -longint'(DEG_20);
         r.command = cmd[27:0];
         r.target = target[31:0];
         r.phase = ph;
         pending_q.push_back(r);
      endfunction

      function void check_result(steer_result_type got);
         steer_result_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result cmd=%0d target=%0d phase=%0d", $time,
                     got.command, got.target, got.phase);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (got.command !== e.command) begin
            $display("%0t: attack_command expected %0d actual %0d", $time, e.command,
                     got.command);
            errors++;
         end
         if (got.target !== e.target) begin
            $display("%0t: target_angle expected %0d actual %0d", $time, e.target,
                     got.target);
            errors++;
         end
         if (got.phase !== e.phase) begin
            $display("%0t: flight_phase expected %0d actual %0d", $time, e.phase,
                     got.phase);
            errors++;
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_ready, req_kind;
   logic [6:0]         req_point_index;
   logic [31:0]        req_point_time, req_sample_time;
   logic signed [31:0] req_point_angle, req_path_angle, req_pitch_attitude;
   logic               rsp_valid, rsp_ready;
   logic signed [27:0] rsp_attack_command;
   logic signed [31:0] rsp_target_angle;
   logic [2:0]         rsp_flight_phase;
   logic               csr_valid, csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;

   pitch_scoreboard_type sb = new();
   int  req_idle_pct, rsp_idle_pct, hold_cycles, filled;

   phase_scheduled_pitch_pid_core uut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #100ms;
      $display("tb failed");
      $finish;
   end

   // transfer monitors
   always @(posedge clock) begin
      step_item_type    it;
      steer_result_type r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it.kind = req_kind;
            it.index = req_point_index;
            it.ptime = req_point_time;
            it.pangle = req_point_angle;
            it.stime = req_sample_time;
            it.path = req_path_angle;
            it.pitch = req_pitch_attitude;
            sb.note_input(it);
         end
         if (rsp_valid && rsp_ready) begin
            r.command = rsp_attack_command;
            r.target = rsp_target_angle;
            r.phase = rsp_flight_phase;
            sb.check_result(r);
         end
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index_type'(csr_index), csr_data);
      end
   end

   // receiver; a long hold-off lets the block back up into its input
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send(step_item_type it);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind <= it.kind;
      req_point_index <= it.index;
      req_point_time <= it.ptime;
      req_point_angle <= it.pangle;
      req_sample_time <= it.stime;
      req_path_angle <= it.path;
      req_pitch_attitude <= it.pitch;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_point(logic [6:0] idx, logic [31:0] t, logic [31:0] a);
      step_item_type it;
      it = '{KIND_LOAD, idx, t, a, $urandom, $urandom, $urandom};
      send(it);
   endtask

   task automatic control(logic [31:0] t, logic [31:0] path, logic [31:0] pitch);
      step_item_type it;
      it = '{KIND_CONTROL, 7'($urandom), $urandom, $urandom, t, path, pitch};
      send(it);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      // a trailing load may still be in flight
      repeat (400) @(negedge clock);
   endtask

   // sorted schedule with targets close to each phase's fixed target
   task automatic build_table(int n);
      logic [31:0] t;
      longint      a;
      t = $urandom_range(0, 40960);
      for (int k = 0; k < n; k++) begin
         a = pitch_scoreboard_type::fixed_target(pitch_scoreboard_type::phase_of(t))
             + longint'($urandom_range(0, 4000000)) - 2000000;
         load_point(k[6:0], t, a[31:0]);
         t = t + $urandom_range(1, 7400000 / n);
      end
      if (n > filled) filled = n;
   endtask

   task automatic random_step();
      logic [31:0] t, path, pitch;
      longint      base;
      int          s;
      if ($urandom_range(0, 99) < 6) begin
         load_point(7'($urandom_range(0, 127)), $urandom, $urandom);
         return;
      end
      s = $urandom_range(0, 99);
      if (s < 70) t = $urandom_range(0, 4096000);
      else if (s < 85) begin
         case ($urandom_range(0, 3))
            0: t = T_CLIMB;
            1: t = T_CRUISE;
            2: t = T_DESCENT;
            default: t = T_TERMINAL;
         endcase
         t = t + $urandom_range(0, 8) - 4;
      end else t = $urandom;
      base = pitch_scoreboard_type::fixed_target(pitch_scoreboard_type::phase_of(t));
      s = $urandom_range(0, 99);
      if (s < 30) path = 32'(base + longint'($urandom_range(0, 18740000)) - 9370000);
      else if (s < 70)
         path = 32'(base + longint'($urandom_range(0, 234254000)) - 117127000);
      else path = $urandom;
      if ($urandom_range(0, 99) < 80)
         pitch = path + $urandom_range(0, 562210000) - 281105000;
      else pitch = $urandom;
      control(t, path, pitch);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_point_index = '0;
      req_point_time = '0;
      req_point_angle = '0;
      req_sample_time = '0;
      req_path_angle = '0;
      req_pitch_attitude = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_idle_pct = 23;
      rsp_idle_pct = 66;
      hold_cycles = 0;
      filled = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, phase boundaries, angle extremes
      control(32'd0, 32'd0, 32'd0);
      control(T_CLIMB - 1, 32'h8000_0000, 32'h7FFF_FFFF);
      control(T_CLIMB, 32'h7FFF_FFFF, 32'h8000_0000);
      control(T_CRUISE - 1, DEG_6, DEG_6);
      control(T_CRUISE, 32'd0, 32'd0);
      control(T_DESCENT - 1, 32'd1000, 32'hFFFF_FFFF);
      control(T_DESCENT, -DEG_2, 32'd0);
      control(T_TERMINAL - 1, 32'd0, DEG_20);
      control(T_TERMINAL, 32'd5, 32'd5);
      control(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      build_table(4);
      wait_idle();

      write_reg(CSR_COUNT, 16'd4);
      write_reg(CSR_KP, 16'h7FFF);
      write_reg(CSR_KI, 16'h8000);
      write_reg(CSR_KD, 16'h7FFF);
      // before the first point, past the last, inside each segment
      control(32'd0, DEG_30, DEG_30);
      control(32'hFFFF_FFFF, 32'd0, 32'd0);
      for (int k = 0; k < 3; k++)
         control((sb.sched_time[k] >> 1) + (sb.sched_time[k+1] >> 1), 32'd0, 32'd0);
      repeat (380) random_step();
      build_table(128);
      wait_idle();

      // count beyond the table depth
      write_reg(CSR_COUNT, 16'd255);
      write_reg(CSR_KP, 16'($urandom_range(0, 65535)));
      write_reg(CSR_KI, 16'($urandom_range(0, 65535)));
      write_reg(CSR_KD, 16'($urandom_range(0, 65535)));
      req_idle_pct = 66;
      rsp_idle_pct = 23;
      repeat (150) random_step();
      wait_idle();

      write_reg(CSR_COUNT, 16'd1);
      write_reg(CSR_KP, 16'h8000);
      write_reg(CSR_KI, 16'h7FFF);
      write_reg(CSR_KD, 16'h8000);
      repeat (280) random_step();
      build_table(16);
      wait_idle();

      write_reg(CSR_COUNT, 16'd16);
      write_reg(CSR_KP, 16'd8192);
      write_reg(CSR_KI, 16'd410);
      write_reg(CSR_KD, 16'd2048);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (40) random_step();
      hold_cycles = 3000;
      repeat (400) random_step();
      wait_idle();

      $display("covered %0d control steps and %0d table loads, %0d results checked",
               sb.controls, sb.loads, sb.checked);
      $display("gain extremes, empty/single/full/oversized tables, phase edges");
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pspp_pkg.sv
design/pspp_ctrl.sv
design/pspp_datapath.sv
design/phase_scheduled_pitch_pid_core.sv
verif/tb.sv
